### sv/aptu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aptu_pkg;

    // default build parameters
    localparam int AVG_LENGTH_DEF  = 5;
    localparam int COUNT_WIDTH_DEF = 16;

    // register and field widths
    localparam int WINDOW_W    = 16;
    localparam int SCALE_W     = 8;
    localparam int SPEED_W     = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;

    // register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 8'd3;

    // largest speed the output can carry
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

    // bit positions in the input tdata
    localparam int PULSE_BIT = 0;
    localparam int TICK_BIT  = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_TICKS = 1'b0,
        CFG_SCALE_FACTOR = 1'b1
    } t_cfg_idx;

endpackage

`default_nettype wire

### sv/averaged_pulse_rate_tachometer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Pulse-rate tachometer with two cascaded moving averages. Each input beat carries a
// pulse flag (tdata bit 0) and a tick flag (tdata bit 1); one beat is taken every cycle
// while o_s_axis_tready is high. Pulses are counted (saturating); when the tick count
// reaches window_ticks the window closes and its count runs through an AVG_LENGTH-entry
// moving sum, then a second AVG_LENGTH-entry moving sum, is scaled by scale_factor and
// leaves as speed = min(65535, floor(scale_factor * sum2 / AVG_LENGTH^2)). The first
// window fills both averaging rings with its own value. A closing beat passes five
// registered stages before its speed beat leaves: the window capture, one for each ring
// update, the scale multiply and the constant division by reciprocal multiply.
// Beats that close no window produce nothing. Every stage is elastic, so input beats keep
// flowing while a result waits at the output until the whole five-stage chain is full.
// Write window_ticks and scale_factor only while no result is in flight.
module averaged_pulse_rate_tachometer_unit #(
    parameter int AVG_LENGTH  = aptu_pkg::AVG_LENGTH_DEF,
    parameter int COUNT_WIDTH = aptu_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input stream, tdata: [0] pulse, [1] tick, [7:2] zero
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [aptu_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // result stream, tdata: [15:0] speed
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [aptu_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [aptu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [aptu_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int PTR_W = $clog2(AVG_LENGTH);
    localparam int S1_W  = COUNT_WIDTH + $clog2(AVG_LENGTH);
    localparam int DIV   = AVG_LENGTH * AVG_LENGTH;
    localparam int DIV_L = $clog2(DIV);
    localparam int S2_W  = COUNT_WIDTH + DIV_L;
    localparam int P_W   = S2_W + aptu_pkg::SCALE_W;
    // products at or above LIM saturate the speed
    localparam longint unsigned LIM = longint'(DIV) * 64'd65536;
    localparam int N_W   = $clog2(LIM);
    localparam longint unsigned RECIP =
        ((64'd1 << (N_W + DIV_L)) + longint'(DIV) - 64'd1) / longint'(DIV);
    localparam int R_W   = $clog2(RECIP + 64'd1);
    localparam int Q_W   = N_W + R_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [PTR_W-1:0]       PTR_LAST  = PTR_W'(AVG_LENGTH - 1);

    // configuration registers
    logic [aptu_pkg::WINDOW_W-1:0] r_window;
    logic [aptu_pkg::SCALE_W-1:0]  r_scale;

    // window counters
    logic [COUNT_WIDTH-1:0]          r_pulse_cnt;
    logic [aptu_pkg::WINDOW_W-1:0]   r_tick_cnt;
    logic [COUNT_WIDTH-1:0]          n_pulse_cnt;
    logic [aptu_pkg::WINDOW_W:0]     n_tick_cnt;
    logic                            w_pulse;
    logic                            w_tick;
    logic                            w_accept;
    logic                            w_close;

    // stage valids and stage readiness
    logic r_c_v, r_a_v, r_b_v, r_p_v, r_o_v;
    logic w_rdy_c, w_rdy_a, w_rdy_b, w_rdy_p, w_rdy_o;

    // captured window count
    logic [COUNT_WIDTH-1:0] r_c_cnt;

    // first averaging ring
    logic [COUNT_WIDTH-1:0] r_s1_samp [AVG_LENGTH];
    logic [S1_W-1:0]        r_s1_sum;
    logic [S1_W-1:0]        n_s1_sum;
    logic [PTR_W-1:0]       r_s1_ptr;
    logic                   r_s1_primed;

    // second averaging ring
    logic [S1_W-1:0]        r_s2_samp [AVG_LENGTH];
    logic [S2_W-1:0]        r_s2_sum;
    logic [S2_W-1:0]        n_s2_sum;
    logic [PTR_W-1:0]       r_s2_ptr;
    logic                   r_s2_primed;

    // scale, division and result
    logic [P_W-1:0]                 r_prod;
    logic [Q_W-1:0]                 n_quot_full;
    logic [aptu_pkg::SPEED_W-1:0]   n_speed;
    logic [aptu_pkg::SPEED_W-1:0]   r_speed;

    // elastic chain: a stage loads when empty or when it hands on
    assign w_rdy_o = !r_o_v || i_m_axis_tready;
    assign w_rdy_p = !r_p_v || w_rdy_o;
    assign w_rdy_b = !r_b_v || w_rdy_p;
    assign w_rdy_a = !r_a_v || w_rdy_b;
    assign w_rdy_c = !r_c_v || w_rdy_a;

    assign o_s_axis_tready = w_rdy_c;
    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = aptu_pkg::OUT_TDATA_W'(r_speed);
    assign o_cfg_ready     = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= aptu_pkg::WINDOW_RESET;
            r_scale  <= aptu_pkg::SCALE_RESET;
        end else if (i_cfg_valid) begin
            unique case (aptu_pkg::t_cfg_idx'(i_cfg_index))
                aptu_pkg::CFG_WINDOW_TICKS: r_window <= i_cfg_data[aptu_pkg::WINDOW_W-1:0];
                aptu_pkg::CFG_SCALE_FACTOR: r_scale  <= i_cfg_data[aptu_pkg::SCALE_W-1:0];
            endcase
        end
    end

    // pulse and tick counting, window close detect
    assign w_accept    = i_s_axis_tvalid && w_rdy_c;
    assign w_pulse     = i_s_axis_tdata[aptu_pkg::PULSE_BIT];
    assign w_tick      = i_s_axis_tdata[aptu_pkg::TICK_BIT];
    assign n_pulse_cnt = (w_pulse && (r_pulse_cnt != COUNT_MAX)) ? r_pulse_cnt + 1'b1
                                                                 : r_pulse_cnt;
    assign n_tick_cnt  = {1'b0, r_tick_cnt} + 1'b1;
    assign w_close     = w_tick && (n_tick_cnt >= {1'b0, r_window});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_cnt <= '0;
            r_tick_cnt  <= '0;
        end else if (w_accept) begin
            if (w_close) begin
                r_pulse_cnt <= '0;
                r_tick_cnt  <= '0;
            end else begin
                r_pulse_cnt <= n_pulse_cnt;
                if (w_tick) begin
                    r_tick_cnt <= n_tick_cnt[aptu_pkg::WINDOW_W-1:0];
                end
            end
        end
    end

    // window count capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_rdy_c) begin
            r_c_v <= w_accept && w_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_close) begin
            r_c_cnt <= n_pulse_cnt;
        end
    end

    // first ring: moving sum of window counts
    assign n_s1_sum = r_s1_sum - S1_W'(r_s1_samp[r_s1_ptr]) + S1_W'(r_c_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v       <= 1'b0;
            r_s1_sum    <= '0;
            r_s1_ptr    <= '0;
            r_s1_primed <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_v <= r_c_v;
            end
            if (r_c_v && w_rdy_a) begin
                if (!r_s1_primed) begin
                    r_s1_sum    <= S1_W'(r_c_cnt) * S1_W'(AVG_LENGTH);
                    r_s1_ptr    <= '0;
                    r_s1_primed <= 1'b1;
                end else begin
                    r_s1_sum <= n_s1_sum;
                    r_s1_ptr <= (r_s1_ptr == PTR_LAST) ? '0 : r_s1_ptr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_v && w_rdy_a) begin
            if (!r_s1_primed) begin
                for (int i = 0; i < AVG_LENGTH; i++) begin
                    r_s1_samp[i] <= r_c_cnt;
                end
            end else begin
                r_s1_samp[r_s1_ptr] <= r_c_cnt;
            end
        end
    end

    // second ring: moving sum of first-ring sums
    assign n_s2_sum = r_s2_sum - S2_W'(r_s2_samp[r_s2_ptr]) + S2_W'(r_s1_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v       <= 1'b0;
            r_s2_sum    <= '0;
            r_s2_ptr    <= '0;
            r_s2_primed <= 1'b0;
        end else begin
            if (w_rdy_b) begin
                r_b_v <= r_a_v;
            end
            if (r_a_v && w_rdy_b) begin
                if (!r_s2_primed) begin
                    r_s2_sum    <= S2_W'(r_s1_sum) * S2_W'(AVG_LENGTH);
                    r_s2_ptr    <= '0;
                    r_s2_primed <= 1'b1;
                end else begin
                    r_s2_sum <= n_s2_sum;
                    r_s2_ptr <= (r_s2_ptr == PTR_LAST) ? '0 : r_s2_ptr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_v && w_rdy_b) begin
            if (!r_s2_primed) begin
                for (int i = 0; i < AVG_LENGTH; i++) begin
                    r_s2_samp[i] <= r_s1_sum;
                end
            end else begin
                r_s2_samp[r_s2_ptr] <= r_s1_sum;
            end
        end
    end

    // scale multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (w_rdy_p) begin
            r_p_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_v && w_rdy_p) begin
            r_prod <= P_W'(r_scale) * P_W'(r_s2_sum);
        end
    end

    // divide by the squared length through reciprocal multiply, then saturate
    assign n_quot_full = Q_W'(r_prod[N_W-1:0]) * Q_W'(RECIP);
    assign n_speed     = (r_prod >= P_W'(LIM)) ? aptu_pkg::SPEED_MAX
                       : aptu_pkg::SPEED_W'(n_quot_full >> (N_W + DIV_L));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_rdy_o) begin
            r_o_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_v && w_rdy_o) begin
            r_speed <= n_speed;
        end
    end

endmodule

`default_nettype wire

### sv/aptu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module aptu_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_s_axis_tvalid,
    input wire logic                               o_s_axis_tready,
    input wire logic [aptu_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input wire logic                               o_m_axis_tvalid,
    input wire logic                               i_m_axis_tready,
    input wire logic [aptu_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    // nothing is offered on the result side straight after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat offered straight after reset");

    // the input side only stalls when a result is waiting and not taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled with no blocked result");

    // a result beat not taken stays offered and unchanged
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result beat dropped or changed");

    // an open result side keeps the input side ready
    a_ready_when_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input not ready while result side is open");

endmodule

bind averaged_pulse_rate_tachometer_unit aptu_checker u_aptu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
